[sv/llmq_pkg.sv]
// ----------------------------------------------------------------------------
// llmq_pkg: shared definitions for the linked-list multi-queue manager
// Sizes, operation and status codes, and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package llmq_pkg;

	localparam int POOL_SIZE  = 64;
	localparam int NUM_QUEUES = 8;
	localparam int DATA_W     = 32;
	localparam int OPC_W      = 2;
	localparam int QID_W      = 3;
	localparam int STS_W      = 2;
	localparam int NODE_W     = $clog2(POOL_SIZE);

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_PEEK,
		OP_CLOSE
	} op_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK,
		ST_NO_FREE,
		ST_EMPTY
	} status_t;

	// Address sources for the link memory ports.
	typedef enum logic [2:0] {
		ADR_SRC_TAIL,
		ADR_DST_TAIL,
		ADR_Q_TAIL,
		ADR_F_TAIL,
		ADR_NODE,
		ADR_RDATA
	} adr_sel_t;

	// Write data sources for the link memory.
	typedef enum logic {
		WD_RDATA,
		WD_NODE
	} wd_sel_t;

	typedef struct packed {
		logic     accept;
		logic     rd_en;
		adr_sel_t rd_sel;
		logic     wr_en;
		adr_sel_t wr_sel;
		wd_sel_t  wd_sel;
		logic     node_ld;
		logic     pay_wr;
		logic     pay_rd;
		logic     src_clear;
		logic     dst_append;
		logic     close_commit;
		logic     res_ld;
	} llmq_cmd_t;

	typedef struct packed {
		op_t  op;
		logic q_ne;
		logic f_ne;
		logic dst_ne;
		logic link_hit;
	} llmq_sts_t;

endpackage

[sv/llmq_if.sv]
// ----------------------------------------------------------------------------
// llmq_if: request and response channels of the queue manager
// Valid/ready channels; a word moves at a clock edge where both are high.
// ----------------------------------------------------------------------------
interface llmq_req_if import llmq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [QID_W-1:0]  queue_id;
	logic [DATA_W-1:0] data_word;

	modport source (output valid, opcode, queue_id, data_word, input ready);
	modport sink   (input valid, opcode, queue_id, data_word, output ready);
endinterface

interface llmq_rsp_if import llmq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STS_W-1:0]  status;
	logic [DATA_W-1:0] head_data;
	logic              queue_empty;

	modport source (output valid, status, head_data, queue_empty, input ready);
	modport sink   (input valid, status, head_data, queue_empty, output ready);
endinterface

[sv/linked_list_multi_queue_manager.sv]
// ----------------------------------------------------------------------------
// linked_list_multi_queue_manager: shared-pool FIFO queue manager
// Eight FIFO queues and a free list kept as circular linked lists in one
// pool of 64 nodes, driven by insert, delete, peek and close requests.
// ----------------------------------------------------------------------------
// Each request word on req carries an opcode, a queue number and a data word,
// and produces exactly one response word on rsp with a status, the data at
// the head of that queue afterwards (zero when it is empty) and an empty
// flag. Requests are handled one at a time: a request occupies the block
// through the chain of dependent accesses to the link memory, whose read
// port is registered. A peek on an empty queue is among the shortest cases;
// an insert or a delete that unlinks a node from a list of two or more and
// appends it to a non-empty list is the longest. The response sits in its
// own register, so a new request is taken while the previous response
// still waits for the sink. After reset the free list already chains every
// node; no initialisation pass is needed.
// ----------------------------------------------------------------------------
module linked_list_multi_queue_manager import llmq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	llmq_req_if.sink   req,
	llmq_rsp_if.source rsp
);

	llmq_cmd_t cmd;
	llmq_sts_t sts;
	logic      in_ready;
	logic      out_valid;

	// The sequencer decides which memory access happens in each cycle.
	llmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath owns all storage, including the response register.
	llmq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (req.opcode),
		.queue_id    (req.queue_id),
		.data_word   (req.data_word),
		.status      (rsp.status),
		.head_data   (rsp.head_data),
		.queue_empty (rsp.queue_empty)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	// An accepted word keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while an operation was starting");

	// An empty queue reports zero head data.
	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.queue_empty) |-> (rsp.head_data == '0))
		else $error("empty queue reported non-zero head data");

	// A queue-empty status always comes with the empty flag.
	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_EMPTY)) |-> rsp.queue_empty)
		else $error("queue-empty status without empty flag");

	// A fresh response is only loaded on leaving the result state, never
	// while a new request is being taken.
	a_load_not_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> !(req.valid && req.ready))
		else $error("response loaded during request acceptance");

endmodule

[sv/llmq_dpath.sv]
// ----------------------------------------------------------------------------
// llmq_dpath: list storage and operand registers
// Holds the link and payload memories, the list tails and occupancy flags,
// and the response register. Every step is ordered by the controller.
// ----------------------------------------------------------------------------
module llmq_dpath import llmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  llmq_cmd_t         cmd,
	output llmq_sts_t         sts,
	input  logic [OPC_W-1:0]  opcode,
	input  logic [QID_W-1:0]  queue_id,
	input  logic [DATA_W-1:0] data_word,
	output logic [STS_W-1:0]  status,
	output logic [DATA_W-1:0] head_data,
	output logic              queue_empty
);

	// Link memory; an entry never written holds the reset chain i -> i+1, with the last node linked back to node 0.
	logic [NODE_W-1:0] link_mem_q [POOL_SIZE];
	logic              link_vld_q [POOL_SIZE];
	logic [NODE_W-1:0] link_word_q;
	logic [NODE_W-1:0] link_addr_q;
	logic              link_hit_q;
	logic [NODE_W-1:0] link_rdata;

	logic [DATA_W-1:0] pay_mem_q [POOL_SIZE];
	logic [DATA_W-1:0] pay_rd_q;

	logic [NODE_W-1:0] qtail_q [NUM_QUEUES];
	logic              qne_q   [NUM_QUEUES];
	logic [NODE_W-1:0] ftail_q;
	logic              fne_q;

	op_t               op_q;
	logic [QID_W-1:0]  qid_q;
	logic [DATA_W-1:0] data_q;
	logic [NODE_W-1:0] node_q;
	status_t           status_q;

	status_t           out_status_q;
	logic [DATA_W-1:0] out_head_q;
	logic              out_empty_q;

	logic              is_del;
	logic [NODE_W-1:0] q_tail;
	logic [NODE_W-1:0] src_tail;
	logic [NODE_W-1:0] dst_tail;
	logic [NODE_W-1:0] rd_addr;
	logic [NODE_W-1:0] wr_addr;
	logic [NODE_W-1:0] wr_data;
	status_t           acc_status;

	assign link_rdata = link_hit_q ? link_word_q :
		((link_addr_q == NODE_W'(POOL_SIZE - 1)) ? '0 : link_addr_q + NODE_W'(1));

	// Delete moves a node from the queue to the free list; insert the reverse.
	assign is_del   = (op_q == OP_DELETE);
	assign q_tail   = qtail_q[qid_q];
	assign src_tail = is_del ? q_tail : ftail_q;
	assign dst_tail = is_del ? ftail_q : q_tail;

	assign sts.op       = op_q;
	assign sts.q_ne     = qne_q[qid_q];
	assign sts.f_ne     = fne_q;
	assign sts.dst_ne   = is_del ? fne_q : qne_q[qid_q];
	assign sts.link_hit = (link_rdata == src_tail);

	function automatic logic [NODE_W-1:0] pick (
		input adr_sel_t          sel,
		input logic [NODE_W-1:0] src,
		input logic [NODE_W-1:0] dst,
		input logic [NODE_W-1:0] qt,
		input logic [NODE_W-1:0] ft,
		input logic [NODE_W-1:0] node,
		input logic [NODE_W-1:0] rdata
	);
		logic [NODE_W-1:0] a;
		case (sel)
			ADR_SRC_TAIL: a = src;
			ADR_DST_TAIL: a = dst;
			ADR_Q_TAIL:   a = qt;
			ADR_F_TAIL:   a = ft;
			ADR_NODE:     a = node;
			ADR_RDATA:    a = rdata;
			default:      a = '0;
		endcase
		return a;
	endfunction

	always_comb begin
		rd_addr = pick(cmd.rd_sel, src_tail, dst_tail, q_tail, ftail_q, node_q, link_rdata);
		wr_addr = pick(cmd.wr_sel, src_tail, dst_tail, q_tail, ftail_q, node_q, link_rdata);
		wr_data = (cmd.wd_sel == WD_NODE) ? node_q : link_rdata;
	end

	always_comb begin
		case (op_t'(opcode))
			OP_INSERT:          acc_status = fne_q ? ST_OK : ST_NO_FREE;
			OP_DELETE, OP_PEEK: acc_status = qne_q[queue_id] ? ST_OK : ST_EMPTY;
			default:            acc_status = ST_OK;
		endcase
	end

	// Link memory array and its registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			link_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			link_word_q <= link_mem_q[rd_addr];
			link_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				link_vld_q[i] <= 1'b0;
			end
			link_hit_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				link_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				link_hit_q <= link_vld_q[rd_addr];
			end
		end
	end

	// Payload memory; the new node index is on the link read data when written.
	always_ff @(posedge clk) begin
		if (cmd.pay_wr) begin
			pay_mem_q[link_rdata] <= data_q;
		end
		if (cmd.pay_rd) begin
			pay_rd_q <= pay_mem_q[link_rdata];
		end
	end

	// List tails and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				qtail_q[i] <= '0;
				qne_q[i]   <= 1'b0;
			end
			ftail_q <= NODE_W'(POOL_SIZE - 1);
			fne_q   <= 1'b1;
		end else begin
			if (cmd.src_clear) begin
				if (is_del) begin
					qne_q[qid_q] <= 1'b0;
				end else begin
					fne_q <= 1'b0;
				end
			end
			if (cmd.dst_append) begin
				if (is_del) begin
					ftail_q <= node_q;
					fne_q   <= 1'b1;
				end else begin
					qtail_q[qid_q] <= node_q;
					qne_q[qid_q]   <= 1'b1;
				end
			end
			if (cmd.close_commit) begin
				ftail_q      <= q_tail;
				fne_q        <= 1'b1;
				qne_q[qid_q] <= 1'b0;
			end
		end
	end

	// Operand and response registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= op_t'(opcode);
			qid_q    <= queue_id;
			data_q   <= data_word;
			status_q <= acc_status;
		end
		if (cmd.node_ld) begin
			node_q <= link_rdata;
		end
		if (cmd.res_ld) begin
			out_status_q <= status_q;
			out_empty_q  <= !qne_q[qid_q];
			out_head_q   <= qne_q[qid_q] ? pay_rd_q : '0;
		end
	end

	assign status      = out_status_q;
	assign head_data   = out_head_q;
	assign queue_empty = out_empty_q;

endmodule

[sv/llmq_ctrl.sv]
// ----------------------------------------------------------------------------
// llmq_ctrl: operation sequencer
// Walks each operation through its link memory reads and writes, one
// access of each kind per cycle, and owns the response valid flag.
// ----------------------------------------------------------------------------
module llmq_ctrl import llmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  llmq_sts_t sts,
	output llmq_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_TAKE1,
		S_TAKE2,
		S_APP0,
		S_APP1,
		S_APP2,
		S_CLS1,
		S_CLS2,
		S_CLS3,
		S_FIN0,
		S_FIN1,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_nxt = S_FIN0;
				case (sts.op)
					OP_INSERT, OP_DELETE: begin
						if ((sts.op == OP_INSERT) ? sts.f_ne : sts.q_ne) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = ADR_SRC_TAIL;
							state_nxt  = S_TAKE1;
						end
					end
					OP_CLOSE: begin
						if (sts.q_ne && sts.f_ne) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = ADR_Q_TAIL;
							state_nxt  = S_CLS1;
						end else if (sts.q_ne) begin
							cmd.close_commit = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_TAKE1: begin
				cmd.node_ld = 1'b1;
				cmd.pay_wr  = (sts.op == OP_INSERT);
				if (sts.link_hit) begin
					cmd.src_clear = 1'b1;
					state_nxt     = S_APP0;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ADR_RDATA;
					state_nxt  = S_TAKE2;
				end
			end
			S_TAKE2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = ADR_SRC_TAIL;
				cmd.wd_sel = WD_RDATA;
				state_nxt  = S_APP0;
			end
			S_APP0: begin
				if (sts.dst_ne) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ADR_DST_TAIL;
					state_nxt  = S_APP1;
				end else begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = ADR_NODE;
					cmd.wd_sel     = WD_NODE;
					cmd.dst_append = 1'b1;
					state_nxt      = S_FIN0;
				end
			end
			S_APP1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = ADR_NODE;
				cmd.wd_sel = WD_RDATA;
				state_nxt  = S_APP2;
			end
			S_APP2: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = ADR_DST_TAIL;
				cmd.wd_sel     = WD_NODE;
				cmd.dst_append = 1'b1;
				state_nxt      = S_FIN0;
			end
			S_CLS1: begin
				cmd.node_ld = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = ADR_F_TAIL;
				state_nxt   = S_CLS2;
			end
			S_CLS2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = ADR_Q_TAIL;
				cmd.wd_sel = WD_RDATA;
				state_nxt  = S_CLS3;
			end
			S_CLS3: begin
				cmd.wr_en        = 1'b1;
				cmd.wr_sel       = ADR_F_TAIL;
				cmd.wd_sel       = WD_NODE;
				cmd.close_commit = 1'b1;
				state_nxt        = S_FIN0;
			end
			S_FIN0: begin
				if (sts.q_ne) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ADR_Q_TAIL;
					state_nxt  = S_FIN1;
				end else begin
					state_nxt = S_EMIT;
				end
			end
			S_FIN1: begin
				cmd.pay_rd = 1'b1;
				state_nxt  = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_ld = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
